// File: hdl/sdfb_pkg.sv
// Shared types, codes and the 16-segment font table for the display frame builder.
// No dependencies; every other file imports this package.
package sdfb_pkg;

    localparam int CHARS_PER_LINE_DEF    = 10;
    localparam int SEGMENTS_PER_CHAR_DEF = 16;

    localparam logic [6:0] SPACE_CODE      = 7'd32;
    localparam logic [6:0] LAST_PRINTABLE  = 7'd126;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_REFRESH = 1'b1;

    typedef enum logic [1:0] {
        KIND_LEAD    = 2'd0,
        KIND_SEGMENT = 2'd1,
        KIND_TRAIL   = 2'd2
    } word_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEAD,
        S_CHAR,
        S_TRAIL,
        S_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic       command;
        logic       line_select;
        logic [3:0] position;
        logic [6:0] char_code;
        logic       common_level;
    } item_t;

    typedef struct packed {
        logic [1:0]  word_kind;
        logic [4:0]  bit_count;
        logic [15:0] serial_word;
        logic        start_strobe;
        logic        last_latch;
    } result_t;

    // controller -> datapath commands
    typedef struct packed {
        logic       store_write;
        logic       load_common;
        logic       issue;
        word_kind_t kind;
        logic       first;
        logic       last;
        logic       lsb_first;
    } ctl_cmd_t;

    localparam logic [15:0] FONT_ROM [95] = '{
        16'h0000, 16'h0101, 16'h0110, 16'hBBDD, 16'h9BD9, 16'h5BDA, 16'h15DD, 16'h0100,
        16'h8380, 16'h01C1, 16'h55AA, 16'h1188, 16'h0002, 16'h1008, 16'h0001, 16'h4002,
        16'hAA55, 16'h6800, 16'hB24D, 16'hBA41, 16'h3818, 16'h8659, 16'h9A5D, 16'hC042,
        16'hBA5D, 16'hBA59, 16'h0048, 16'h004A, 16'h4400, 16'h1209, 16'h0022, 16'hB0C0,
        16'hBAD5, 16'hB85C, 16'hBBC1, 16'h8255, 16'hABC1, 16'h825D, 16'h805C, 16'h9A55,
        16'h381C, 16'h83C1, 16'h2A05, 16'h441C, 16'h0215, 16'h6834, 16'h2C34, 16'hAA55,
        16'hB05C, 16'hAE55, 16'hB45C, 16'h9A59, 16'h81C0, 16'h2A15, 16'h4016, 16'h2C16,
        16'h4422, 16'h40A0, 16'hC243, 16'h8255, 16'h0420, 16'hAA41, 16'h0402, 16'h0201,
        16'h0100, 16'h028D, 16'h009D, 16'h000D, 16'h018D, 16'h000F, 16'h9188, 16'h01D9,
        16'h009C, 16'h8080, 16'h0181, 16'h1580, 16'h0180, 16'h188C, 16'h1888, 16'h008D,
        16'h015C, 16'h03D8, 16'h1080, 16'h1600, 16'h1188, 16'h0285, 16'h0006, 16'h0A85,
        16'h4422, 16'h0199, 16'h000B, 16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

    // unprintable codes show blank
    function automatic logic [15:0] font_glyph(input logic [6:0] code);
        logic [15:0] g;
        g = 16'h0000;
        if (code >= SPACE_CODE && code <= LAST_PRINTABLE)
        begin
            g = FONT_ROM[code - SPACE_CODE];
        end
        return g;
    endfunction

    function automatic logic [15:0] reverse16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++)
        begin
            r[i] = v[15 - i];
        end
        return r;
    endfunction

endpackage

// File: hdl/sdfb_ctrl.sv
// Sequencer for the frame builder: walks lead, characters and trail of both halves.
// Depends on sdfb_pkg; drives sdfb_datapath through ctl_cmd_t and a store address.
module sdfb_ctrl
    import sdfb_pkg::*;
#(
    parameter int CHARS_PER_LINE = CHARS_PER_LINE_DEF,
    localparam int ADDR_W = $clog2(2 * CHARS_PER_LINE),
    localparam int POS_W  = (CHARS_PER_LINE > 1) ? $clog2(CHARS_PER_LINE) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              command,
    output logic              busy,
    output ctl_cmd_t          cmd,
    output logic [ADDR_W-1:0] rd_addr
);

    localparam logic [POS_W-1:0]  LastPos  = POS_W'(CHARS_PER_LINE - 1);
    localparam logic [ADDR_W-1:0] BotBase  = ADDR_W'(CHARS_PER_LINE);

    ctrl_state_t      state_reg, state_next;
    logic             half_reg, half_next;   // 0 bottom line, 1 top line
    logic [POS_W-1:0] chr_reg, chr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            half_reg  <= 1'b0;
            chr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg  <= half_next;
            chr_reg   <= chr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        half_next  = half_reg;
        chr_next   = chr_reg;
        cmd        = '{default: '0, kind: KIND_LEAD};
        rd_addr    = '0;
        busy       = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (command == CMD_REFRESH)
                    begin
                        cmd.load_common = 1'b1;
                        half_next       = 1'b0;
                        state_next      = S_LEAD;
                    end
                    else
                    begin
                        cmd.store_write = 1'b1;
                    end
                end
            end
            S_LEAD:
            begin
                cmd.issue  = 1'b1;
                cmd.kind   = KIND_LEAD;
                cmd.first  = ~half_reg;
                chr_next   = half_reg ? '0 : LastPos;
                state_next = S_CHAR;
            end
            S_CHAR:
            begin
                cmd.issue     = 1'b1;
                cmd.kind      = KIND_SEGMENT;
                cmd.lsb_first = half_reg;
                rd_addr       = half_reg ? ADDR_W'(chr_reg) : BotBase + ADDR_W'(chr_reg);
                if (half_reg)
                begin
                    if (chr_reg == LastPos)
                        state_next = S_TRAIL;
                    else
                        chr_next = chr_reg + 1'b1;
                end
                else
                begin
                    if (chr_reg == '0)
                        state_next = S_TRAIL;
                    else
                        chr_next = chr_reg - 1'b1;
                end
            end
            S_TRAIL:
            begin
                cmd.issue = 1'b1;
                cmd.kind  = KIND_TRAIL;
                cmd.last  = half_reg;
                if (half_reg)
                    state_next = S_FLUSH;
                else
                begin
                    half_next  = 1'b1;
                    state_next = S_LEAD;
                end
            end
            S_FLUSH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/sdfb_datapath.sv
// Character store, font lookup and result register of the frame builder.
// Depends on sdfb_pkg; commanded by sdfb_ctrl.
module sdfb_datapath
    import sdfb_pkg::*;
#(
    parameter int CHARS_PER_LINE    = CHARS_PER_LINE_DEF,
    parameter int SEGMENTS_PER_CHAR = SEGMENTS_PER_CHAR_DEF,
    localparam int DEPTH  = 2 * CHARS_PER_LINE,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  item_t             item,
    input  ctl_cmd_t          cmd,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              cfg_we,
    input  logic              cfg_data,
    output logic              strobe,
    output result_t           result
);

    localparam logic [15:0] WordMask = ~(16'hFFFF >> SEGMENTS_PER_CHAR);
    localparam logic [4:0]  SegCount = 5'(SEGMENTS_PER_CHAR);

    logic [6:0]        mem_reg [DEPTH];
    logic [DEPTH-1:0]  valid_reg;        // entry written since reset
    logic              bg_reg;
    logic              common_reg;

    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;

    // read stage
    logic [6:0]        rd_code_reg;
    logic              rd_hit_reg;
    logic              s1_valid_reg;
    word_kind_t        s1_kind_reg;
    logic              s1_first_reg, s1_last_reg, s1_lsb_reg;

    // result register
    logic              strobe_reg;
    result_t           result_reg;
    result_t           result_next;

    logic [6:0]        code_sel;
    logic [15:0]       seg;

    always_comb
    begin
        wr_addr = item.line_select ? ADDR_W'(CHARS_PER_LINE) + ADDR_W'(item.position)
                                   : ADDR_W'(item.position);
        wr_en   = cmd.store_write && ({2'b00, item.position} < 6'(CHARS_PER_LINE));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= item.char_code;
        rd_code_reg <= mem_reg[rd_addr];
        rd_hit_reg  <= valid_reg[rd_addr];
        s1_kind_reg  <= cmd.kind;
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_lsb_reg   <= cmd.lsb_first;
        result_reg   <= result_next;
        if (cmd.load_common)
            common_reg <= item.common_level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            bg_reg       <= 1'b0;
            s1_valid_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (cfg_we)
                bg_reg <= cfg_data;
            s1_valid_reg <= cmd.issue;
            strobe_reg   <= s1_valid_reg;
        end
    end

    always_comb
    begin
        code_sel = rd_hit_reg ? rd_code_reg : SPACE_CODE;
        seg      = font_glyph(code_sel) ^ {16{bg_reg}};
        if (s1_lsb_reg)
            seg = reverse16(seg);
        seg = seg & WordMask;

        result_next              = '0;
        result_next.word_kind    = s1_kind_reg;
        result_next.start_strobe = s1_first_reg;
        result_next.last_latch   = s1_last_reg;
        case (s1_kind_reg)
            KIND_LEAD:
            begin
                result_next.bit_count   = 5'd1;
                result_next.serial_word = {15'b0, bg_reg};
            end
            KIND_SEGMENT:
            begin
                result_next.bit_count   = SegCount;
                result_next.serial_word = seg;
            end
            KIND_TRAIL:
            begin
                result_next.bit_count   = 5'd1;
                result_next.serial_word = {15'b0, common_reg};
            end
            default:
            begin
                result_next.bit_count   = 5'd1;
                result_next.serial_word = '0;
            end
        endcase
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// File: hdl/segment_display_frame_builder.sv
// Top level of the two-row 16-segment display frame builder.
// Depends on sdfb_pkg, sdfb_ctrl and sdfb_datapath.
//
//  channel  | handshake              | payload  | note
//  ---------+------------------------+----------+-------------------------------
//  item     | start & !busy          | item_t   | write a code or run a refresh
//  result   | strobe (one cycle)     | result_t | no back-pressure
//  config   | cfg_valid & cfg_ready  | cfg_data | background_black
//
// A write beat never raises busy.
// A refresh beat holds busy while the sequencer issues one result per cycle
// through both halves and then passes its flush state, as each issue goes
// through the store's registered read and the result register.
// Results stream with no gaps inside a frame;
// busy drops as the last result reaches the ports.
// Reset clears the sequencer, the background bit and the store's written
// flags, so every position reads as a space until written.
// The receiver cannot stall; cfg_ready is low while a frame is in flight.
module segment_display_frame_builder
    import sdfb_pkg::*;
#(
    parameter int CHARS_PER_LINE    = CHARS_PER_LINE_DEF,
    parameter int SEGMENTS_PER_CHAR = SEGMENTS_PER_CHAR_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    strobe,
    output result_t result,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic    cfg_data
);

    localparam int ADDR_W = $clog2(2 * CHARS_PER_LINE);

    ctl_cmd_t          cmd;
    logic [ADDR_W-1:0] rd_addr;

    // config only lands between frames
    assign cfg_ready = ~busy;

    sdfb_ctrl #(
        .CHARS_PER_LINE (CHARS_PER_LINE)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (item.command),
        .busy    (busy),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    sdfb_datapath #(
        .CHARS_PER_LINE    (CHARS_PER_LINE),
        .SEGMENTS_PER_CHAR (SEGMENTS_PER_CHAR)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .strobe   (strobe),
        .result   (result)
    );

endmodule

// File: hdl/sdfb_checker.sv
// Port-level checks for the frame builder, bound onto the top level.
// Depends on sdfb_pkg and segment_display_frame_builder.
module sdfb_checker
    import sdfb_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input item_t   item,
    input logic    strobe,
    input result_t result
);

    // frame opens with a lead bit
    a_first_is_lead: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.start_strobe |-> result.word_kind == KIND_LEAD)
        else $error("frame start is not a lead bit");

    // frame closes with a common bit
    a_last_is_trail: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last_latch |-> result.word_kind == KIND_TRAIL)
        else $error("frame end is not a trailing common bit");

    // single bits carry a count of one
    a_single_count: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.word_kind != KIND_SEGMENT |-> result.bit_count == 5'd1)
        else $error("single-bit beat with wrong bit count");

    // no gaps inside a frame
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_latch |=> strobe)
        else $error("gap inside a frame");

    // a refresh holds off further beats
    a_refresh_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command == CMD_REFRESH |=> busy)
        else $error("busy did not rise after refresh");

endmodule

bind segment_display_frame_builder sdfb_checker u_sdfb_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
);

// File: verif/sdfb_frame_checker.sv
// Scoreboard for the display frame builder: tracks the character store and the
// background bit, builds each expected frame and compares every result beat.
// Depends on sdfb_pkg for the item and result types and the word kinds.
module sdfb_frame_checker
    import sdfb_pkg::*;
#(
    parameter int CHARS_PER_LINE    = CHARS_PER_LINE_DEF,
    parameter int SEGMENTS_PER_CHAR = SEGMENTS_PER_CHAR_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   item,
    input  logic    strobe,
    input  result_t result,
    input  logic    cfg_valid,
    input  logic    cfg_ready,
    input  logic    cfg_data,
    output int      errors,
    output int      pending,
    output int      checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAME_LEN   = 2 * (CHARS_PER_LINE + 2);
    localparam int          MAX_REPORTS = 10;
    localparam logic [15:0] SEG_MASK    = 16'hFFFF << (16 - SEGMENTS_PER_CHAR);

    // segment patterns for codes 32..126
    localparam logic [15:0] GLYPHS [95] = '{
        16'h0000, 16'h0101, 16'h0110, 16'hBBDD, 16'h9BD9, 16'h5BDA, 16'h15DD, 16'h0100,
        16'h8380, 16'h01C1, 16'h55AA, 16'h1188, 16'h0002, 16'h1008, 16'h0001, 16'h4002,
        16'hAA55, 16'h6800, 16'hB24D, 16'hBA41, 16'h3818, 16'h8659, 16'h9A5D, 16'hC042,
        16'hBA5D, 16'hBA59, 16'h0048, 16'h004A, 16'h4400, 16'h1209, 16'h0022, 16'hB0C0,
        16'hBAD5, 16'hB85C, 16'hBBC1, 16'h8255, 16'hABC1, 16'h825D, 16'h805C, 16'h9A55,
        16'h381C, 16'h83C1, 16'h2A05, 16'h441C, 16'h0215, 16'h6834, 16'h2C34, 16'hAA55,
        16'hB05C, 16'hAE55, 16'hB45C, 16'h9A59, 16'h81C0, 16'h2A15, 16'h4016, 16'h2C16,
        16'h4422, 16'h40A0, 16'hC243, 16'h8255, 16'h0420, 16'hAA41, 16'h0402, 16'h0201,
        16'h0100, 16'h028D, 16'h009D, 16'h000D, 16'h018D, 16'h000F, 16'h9188, 16'h01D9,
        16'h009C, 16'h8080, 16'h0181, 16'h1580, 16'h0180, 16'h188C, 16'h1888, 16'h008D,
        16'h015C, 16'h03D8, 16'h1080, 16'h1600, 16'h1188, 16'h0285, 16'h0006, 16'h0A85,
        16'h4422, 16'h0199, 16'h000B, 16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

    logic [6:0] shown_codes [2 * CHARS_PER_LINE];
    logic       bg_is_black;
    int         frame_pos;
    result_t    frame_q [$];
    result_t    want;

    // one character's serial word: blank for unprintable, inverted on black,
    // bit-mirrored for the top line, trimmed to the segment count
    function automatic logic [15:0] segment_bits(input logic [6:0] code,
                                                 input logic bg,
                                                 input logic mirrored);
        logic [15:0] w;
        logic [15:0] flipped;
        w = 16'h0000;
        if (code >= SPACE_CODE && code <= LAST_PRINTABLE)
        begin
            w = GLYPHS[code - SPACE_CODE];
        end
        if (bg)
        begin
            w = ~w;
        end
        flipped = w;
        if (mirrored)
        begin
            for (int i = 0; i < 16; i++)
            begin
                flipped[i] = w[15 - i];
            end
        end
        return flipped & SEG_MASK;
    endfunction

    task automatic queue_beat(input word_kind_t kind, input logic [4:0] count,
                              input logic [15:0] bits);
        result_t r;
        r.word_kind    = kind;
        r.bit_count    = count;
        r.serial_word  = bits;
        r.start_strobe = (frame_pos == 0);
        r.last_latch   = (frame_pos == FRAME_LEN - 1);
        frame_q.push_back(r);
        frame_pos++;
    endtask

    // bottom line right to left, MSB first; top line left to right, mirrored
    task automatic queue_frame(input logic common);
        frame_pos = 0;
        queue_beat(KIND_LEAD, 5'd1, {15'd0, bg_is_black});
        for (int i = CHARS_PER_LINE - 1; i >= 0; i--)
        begin
            queue_beat(KIND_SEGMENT, 5'(SEGMENTS_PER_CHAR),
                       segment_bits(shown_codes[CHARS_PER_LINE + i], bg_is_black, 1'b0));
        end
        queue_beat(KIND_TRAIL, 5'd1, {15'd0, common});
        queue_beat(KIND_LEAD, 5'd1, {15'd0, bg_is_black});
        for (int i = 0; i < CHARS_PER_LINE; i++)
        begin
            queue_beat(KIND_SEGMENT, 5'(SEGMENTS_PER_CHAR),
                       segment_bits(shown_codes[i], bg_is_black, 1'b1));
        end
        queue_beat(KIND_TRAIL, 5'd1, {15'd0, common});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2 * CHARS_PER_LINE; i++)
            begin
                shown_codes[i] = SPACE_CODE;
            end
            bg_is_black = 1'b0;
            frame_q.delete();
            pending  = 0;
            errors   = 0;
            checked  = 0;
        end
        else
        begin
            // a beat leaving this edge belongs to an earlier frame: check first
            if (strobe)
            begin
                if (frame_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display({"%0t: result beat with nothing outstanding: ",
                                  "kind=%0d count=%0d word=%h start=%b latch=%b"},
                                 $realtime, result.word_kind, result.bit_count,
                                 result.serial_word, result.start_strobe, result.last_latch);
                    end
                end
                else
                begin
                    want = frame_q.pop_front();
                    checked++;
                    if (result !== want)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display({"%0t: mismatch want kind=%0d count=%0d word=%h ",
                                      "start=%b latch=%b"},
                                     $realtime, want.word_kind, want.bit_count,
                                     want.serial_word, want.start_strobe, want.last_latch);
                            $display({"%0t:          got  kind=%0d count=%0d word=%h ",
                                      "start=%b latch=%b"},
                                     $realtime, result.word_kind, result.bit_count,
                                     result.serial_word, result.start_strobe,
                                     result.last_latch);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                bg_is_black = cfg_data;
            end
            if (start && !busy)
            begin
                if (item.command == CMD_REFRESH)
                begin
                    queue_frame(item.common_level);
                end
                else if (item.position < CHARS_PER_LINE)
                begin
                    shown_codes[item.line_select * CHARS_PER_LINE + item.position] =
                        item.char_code;
                end
            end
            pending = frame_q.size();
        end
    end

endmodule

// File: verif/tb_top.sv
// Top of the display frame builder testbench: clock, reset, item and
// background stimulus, and the verdict. Depends on sdfb_pkg,
// segment_display_frame_builder and sdfb_frame_checker.
module tb_top
    import sdfb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CPL          = CHARS_PER_LINE_DEF;
    localparam int RANDOM_ITEMS = 140;
    localparam int PHASES       = 4;
    // spare cycles waited once busy and the outstanding beats have cleared
    localparam int SETTLE       = 8;
    localparam int DRAIN_LIMIT  = 3000;
    // watchdog bound, above the slowest legal run of items, busy windows and gaps
    localparam int unsigned CYCLE_LIMIT = 200_000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    strobe;
    result_t result;
    logic    cfg_valid;
    logic    cfg_ready;
    logic    cfg_data;

    int errors;
    int pending;
    int checked;

    int writes_sent;
    int dropped_writes;
    int frames_sent;
    int bg_writes;
    bit gaps_on;

    segment_display_frame_builder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .strobe    (strobe),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sdfb_frame_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .strobe    (strobe),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // watchdog: a hung handshake or a lost frame ends the run here
    initial
    begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d beats still outstanding", cycles, pending);
        $display("*** FAILED ***");
        $finish;
    end

    // Present one item and hold it until the edge that takes it.
    // start is left high so back-to-back beats need no second assignment;
    // hold_off or drain_frames lowers it.
    task automatic drive_item(input item_t it);
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        if (it.command == CMD_REFRESH)
        begin
            frames_sent++;
        end
        else if (it.position < CPL)
        begin
            writes_sent++;
        end
        else
        begin
            dropped_writes++;
        end
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    // start held low for the given gap; the payload wanders meanwhile, it must be ignored
    task automatic hold_off(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            item  <= item_t'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Mostly back-to-back or short gaps, now and then a long one so that the
    // next beat lands on every phase of a running frame.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 40)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Stop sending and wait out every outstanding beat plus the tail of busy.
    task automatic drain_frames();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    // background register only changes with the block idle
    task automatic write_background(input logic black);
        drain_frames();
        cfg_valid <= 1'b1;
        cfg_data  <= black;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        bg_writes++;
    endtask

    function automatic item_t store_beat(input logic line, input logic [3:0] pos,
                                         input logic [6:0] code);
        item_t it;
        it              = item_t'($urandom);
        it.command      = CMD_WRITE;
        it.line_select  = line;
        it.position     = pos;
        it.char_code    = code;
        return it;
    endfunction

    function automatic item_t refresh_beat(input logic common);
        item_t it;
        it              = item_t'($urandom);
        it.command      = CMD_REFRESH;
        it.common_level = common;
        return it;
    endfunction

    // Random traffic: about a third refreshes, writes mostly in range with
    // printable codes, the rest off the line or with any code.
    function automatic item_t random_beat();
        item_t it;
        it = item_t'($urandom);
        if ($urandom_range(0, 99) < 35)
        begin
            it.command = CMD_REFRESH;
        end
        else
        begin
            it.command  = CMD_WRITE;
            it.position = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, CPL - 1))
                                                       : 4'($urandom_range(CPL, 15));
            it.char_code = ($urandom_range(0, 99) < 80) ? 7'($urandom_range(32, 126))
                                                        : 7'($urandom_range(0, 127));
        end
        return it;
    endfunction

    initial
    begin
        item_t it;
        int    counted;

        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        cfg_valid      = 1'b0;
        cfg_data       = 1'b0;
        writes_sent    = 0;
        dropped_writes = 0;
        frames_sent    = 0;
        bg_writes      = 0;
        gaps_on        = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed: white background ----
        write_background(1'b0);
        drive_item(refresh_beat(1'b0));                  // all-space frame from reset
        drive_item(store_beat(1'b0, 4'd0, 7'd0));        // lowest code, unprintable
        drive_item(store_beat(1'b0, 4'd9, 7'd127));      // highest code, unprintable
        drive_item(store_beat(1'b1, 4'd0, SPACE_CODE));  // first printable
        drive_item(store_beat(1'b1, 4'd9, LAST_PRINTABLE));
        drive_item(store_beat(1'b1, 4'd5, 7'd31));       // just below printable
        drive_item(store_beat(1'b0, 4'd4, 7'd33));
        drive_item(store_beat(1'b1, 4'd15, 7'd65));      // position off the line: dropped
        drive_item(store_beat(1'b0, 4'd10, 7'd72));      // first position past the end
        drive_item(refresh_beat(1'b0));
        drive_item(refresh_beat(1'b1));                  // back-to-back frames

        // ---- directed: black background inverts every segment word ----
        write_background(1'b1);
        drive_item(refresh_beat(1'b1));
        drive_item(store_beat(1'b0, 4'd0, LAST_PRINTABLE));
        drive_item(store_beat(1'b1, 4'd9, 7'd0));
        drive_item(store_beat(1'b1, 4'd3, 7'd77));
        drive_item(refresh_beat(1'b0));

        // ---- random phases, background flipped between them ----
        // phase 2 runs with no idle cycles at all
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_background(phase == 0 ? 1'b0 :
                             phase == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
            gaps_on = (phase != 2);
            counted = 0;
            while (counted < RANDOM_ITEMS / PHASES + 1)
            begin
                hold_off(pick_gap());
                it = random_beat();
                drive_item(it);
                if (it.command == CMD_REFRESH || it.position < CPL)
                begin
                    counted++;
                end
                // sender backs off completely once mid-phase
                if (phase == 1 && counted == 20)
                begin
                    drain_frames();
                end
            end
        end

        // ---- wind down ----
        @(negedge clk);
        start <= 1'b0;
        begin
            int waited;
            waited = 0;
            while (pending != 0 && waited < DRAIN_LIMIT)
            begin
                @(negedge clk);
                waited++;
            end
        end
        repeat (4 * SETTLE) @(negedge clk);

        $display("ran %0d stores (%0d off-line drops), %0d refresh frames, %0d background writes",
                 writes_sent, dropped_writes, frames_sent, bg_writes);
        $display("checked %0d result beats, %0d mismatches, %0d beats never seen",
                 checked, errors, pending);
        if (errors == 0 && pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/sdfb_pkg.sv
hdl/sdfb_ctrl.sv
hdl/sdfb_datapath.sv
hdl/segment_display_frame_builder.sv
hdl/sdfb_checker.sv
verif/sdfb_frame_checker.sv
verif/tb_top.sv
